### hw/rtl/crl_pkg.sv
// Package for the client connection rate limiter.
// Holds payload structs, state and action codes, and default sizes.
// No dependencies.
`timescale 1ns / 1ps

package crl_pkg;

  localparam int TABLE_ENTRIES_DEF = 4 * 1024;
  localparam int PROBE_LIMIT_DEF   = 16;
  localparam int WINDOW_SLOTS_DEF  = 10;
  localparam int TICK_SECONDS_DEF  = 6;

  localparam logic [31:0] HASH_SEED = 32'd5381;
  localparam int COUNT_W = 16;
  localparam int SUM_W   = 20;
  localparam int SLOT_W  = 12;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [SUM_W-1:0]   SUM_MAX   = '1;

  typedef enum logic [1:0] {
    ACT_CONTINUE = 2'd0,
    ACT_TEMPFAIL = 2'd1,
    ACT_DROP     = 2'd2
  } action_t;

  typedef struct packed {
    logic [63:0] addr_high;
    logic [63:0] addr_low;
    logic [31:0] now_seconds;
    logic [19:0] conn_limit;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        action;
    logic [SUM_W-1:0]  connection_count;
    logic [SLOT_W-1:0] slot_index;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_DIVT,
    ST_DIVM,
    ST_PRB_RD,
    ST_PRB_CK,
    ST_BASE,
    ST_WIPE,
    ST_UPD_RD,
    ST_UPD_WR,
    ST_SUM_RD,
    ST_SUM_CK,
    ST_DONE
  } state_t;

endpackage

### hw/rtl/crl_ram.sv
// Generic single write port, single read port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps

module crl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, then registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/client_connection_rate_limiter_unit.sv
// Timing: a zero limit goes from the idle state straight to the result state; otherwise the time
// to out_valid grows with the probe count P = 1..PROBE_LIMIT and with a miss, and is set by the
// byte-serial hash, two passes through the shared reciprocal multiplier and the single read port
// of each RAM; a stalled output adds its stall.
// Throughput: one item at a time; in_ready is high only in the idle state.
// Reset: rst_n low clears control; afterwards a clearing pass of
// TABLE_ENTRIES*WINDOW_SLOTS bucket addresses zeroes the tables and holds in_ready low.
`timescale 1ns / 1ps

module client_connection_rate_limiter_unit #(
  parameter int TABLE_ENTRIES = crl_pkg::TABLE_ENTRIES_DEF,
  parameter int PROBE_LIMIT   = crl_pkg::PROBE_LIMIT_DEF,
  parameter int WINDOW_SLOTS  = crl_pkg::WINDOW_SLOTS_DEF,
  parameter int TICK_SECONDS  = crl_pkg::TICK_SECONDS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  crl_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output crl_pkg::out_item_t  out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_data
);

  localparam int IDX_W     = $clog2(TABLE_ENTRIES);
  localparam int BKT_DEPTH = TABLE_ENTRIES * WINDOW_SLOTS;
  localparam int BA_W      = $clog2(BKT_DEPTH);
  localparam longint unsigned TICK_MAX = 64'hFFFF_FFFF / TICK_SECONDS;
  localparam int TICK_W    = $clog2(TICK_MAX + 1);
  localparam int CW        = crl_pkg::COUNT_W;
  localparam int SW        = crl_pkg::SUM_W;
  localparam int OW        = crl_pkg::SLOT_W;
  localparam int BKT_W     = TICK_W + CW;
  localparam int WI_W      = $clog2(WINDOW_SLOTS);
  localparam int HASH_BYTES = 16;
  localparam int STEP_A    = (PROBE_LIMIT > HASH_BYTES) ? PROBE_LIMIT : HASH_BYTES;
  localparam int STEP_MAX  = (STEP_A > WINDOW_SLOTS) ? STEP_A : WINDOW_SLOTS;
  localparam int CNT_W     = $clog2(STEP_MAX);

  // Reciprocals for exact 32-bit division by the constants: ceil(2^SH / d), shift SH.
  localparam int SH_T = 32 + $clog2(TICK_SECONDS);
  localparam int SH_W = 32 + $clog2(WINDOW_SLOTS);
  localparam longint unsigned MAG_T_L =
    ((64'd1 << SH_T) + 64'(TICK_SECONDS) - 64'd1) / 64'(TICK_SECONDS);
  localparam longint unsigned MAG_W_L =
    ((64'd1 << SH_W) + 64'(WINDOW_SLOTS) - 64'd1) / 64'(WINDOW_SLOTS);
  localparam logic [32:0] MAG_T = MAG_T_L[32:0];
  localparam logic [32:0] MAG_W = MAG_W_L[32:0];

  crl_pkg::state_t state_r, state_nxt;

  logic [BA_W-1:0]  clr_r, clr_nxt;
  logic [CNT_W-1:0] step_r, step_nxt;
  logic [127:0]     key_r, key_nxt;
  logic [127:0]     addr_r, addr_nxt;
  logic [31:0]      now_r, now_nxt;
  logic [19:0]      limit_r, limit_nxt;
  logic [31:0]      h_r, h_nxt;
  logic [31:0]      quo_r, quo_nxt;
  logic [TICK_W-1:0] tick_r, tick_nxt;
  logic [WI_W-1:0]  off_r, off_nxt;
  logic [IDX_W-1:0] prb_r, prb_nxt;
  logic [IDX_W-1:0] oldest_r, oldest_nxt;
  logic [31:0]      oldest_lt_r, oldest_lt_nxt;
  logic [IDX_W-1:0] slot_r, slot_nxt;
  logic             found_r, found_nxt;
  logic [BA_W-1:0]  base_r, base_nxt;
  logic [SW-1:0]    sum_r, sum_nxt;
  logic             drop_r;
  logic             out_valid_r, out_valid_nxt;
  crl_pkg::out_item_t out_r, out_nxt;

  // RAM ports.
  logic             a_we, t_we, b_we;
  logic [IDX_W-1:0] a_waddr, t_waddr, a_raddr;
  logic [127:0]     a_wdata, a_q;
  logic [31:0]      t_wdata, t_q;
  logic [BA_W-1:0]  b_waddr, b_raddr;
  logic [BKT_W-1:0] b_wdata, b_q;

  // Shared multiplier and helpers.
  logic [31:0]      mul_a;
  logic [32:0]      mul_b;
  logic [64:0]      mul_p;
  logic [31:0]      mul_q;
  logic [TICK_W-1:0] b_tick, b_diff;
  logic [CW-1:0]    b_cnt, b_newcnt;
  logic [SW:0]      sum_wide;

  crl_ram #(.WIDTH(128), .DEPTH(TABLE_ENTRIES)) u_addr_ram (
    .clk(clk), .we(a_we), .waddr(a_waddr), .wdata(a_wdata), .raddr(a_raddr), .rdata(a_q)
  );
  crl_ram #(.WIDTH(32), .DEPTH(TABLE_ENTRIES)) u_touch_ram (
    .clk(clk), .we(t_we), .waddr(t_waddr), .wdata(t_wdata), .raddr(a_raddr), .rdata(t_q)
  );
  crl_ram #(.WIDTH(BKT_W), .DEPTH(BKT_DEPTH)) u_bkt_ram (
    .clk(clk), .we(b_we), .waddr(b_waddr), .wdata(b_wdata), .raddr(b_raddr), .rdata(b_q)
  );

  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drop_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      drop_r <= cfg_data;
    end
  end

  // Control and datapath registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= crl_pkg::ST_CLEAR;
      clr_r       <= '0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
    key_r       <= key_nxt;
    addr_r      <= addr_nxt;
    now_r       <= now_nxt;
    limit_r     <= limit_nxt;
    h_r         <= h_nxt;
    quo_r       <= quo_nxt;
    tick_r      <= tick_nxt;
    off_r       <= off_nxt;
    prb_r       <= prb_nxt;
    oldest_r    <= oldest_nxt;
    oldest_lt_r <= oldest_lt_nxt;
    slot_r      <= slot_nxt;
    found_r     <= found_nxt;
    base_r      <= base_nxt;
    sum_r       <= sum_nxt;
    out_r       <= out_nxt;
  end

  // Shared reciprocal multiplier: now / TICK_SECONDS first, then tick / WINDOW_SLOTS.
  assign mul_a = (state_r == crl_pkg::ST_DIVT) ? now_r : 32'(tick_r);
  assign mul_b = (state_r == crl_pkg::ST_DIVT) ? MAG_T : MAG_W;
  assign mul_p = 65'(mul_a) * 65'(mul_b);
  assign mul_q = (state_r == crl_pkg::ST_DIVT) ? 32'(mul_p >> SH_T) : 32'(mul_p >> SH_W);

  // Bucket fields as read.
  assign b_tick   = b_q[BKT_W-1:CW];
  assign b_cnt    = b_q[CW-1:0];
  assign b_diff   = tick_r - b_tick;
  assign b_newcnt = ((b_tick != tick_r) ? CW'(1)
                   : ((b_cnt < crl_pkg::COUNT_MAX) ? b_cnt + CW'(1) : b_cnt));
  assign sum_wide = {1'b0, sum_r} + (SW + 1)'(b_cnt);

  // Sequencer.
  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    step_nxt      = step_r;
    key_nxt       = key_r;
    addr_nxt      = addr_r;
    now_nxt       = now_r;
    limit_nxt     = limit_r;
    h_nxt         = h_r;
    quo_nxt       = quo_r;
    tick_nxt      = tick_r;
    off_nxt       = off_r;
    prb_nxt       = prb_r;
    oldest_nxt    = oldest_r;
    oldest_lt_nxt = oldest_lt_r;
    slot_nxt      = slot_r;
    found_nxt     = found_r;
    base_nxt      = base_r;
    sum_nxt       = sum_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    in_ready      = 1'b0;
    a_we    = 1'b0;
    a_waddr = slot_r;
    a_wdata = addr_r;
    t_we    = 1'b0;
    t_waddr = slot_r;
    t_wdata = now_r;
    b_we    = 1'b0;
    b_waddr = base_r + BA_W'(step_r);
    b_wdata = '0;
    a_raddr = prb_r;
    b_raddr = base_r + BA_W'(off_r);

    case (state_r)
      // Zero every table entry after reset.
      crl_pkg::ST_CLEAR: begin
        a_we    = 1'b1;
        a_waddr = clr_r[IDX_W-1:0];
        a_wdata = '0;
        t_we    = 1'b1;
        t_waddr = clr_r[IDX_W-1:0];
        t_wdata = '0;
        b_we    = 1'b1;
        b_waddr = clr_r;
        clr_nxt = clr_r + BA_W'(1);
        if (clr_r == BA_W'(BKT_DEPTH - 1)) begin
          state_nxt = crl_pkg::ST_IDLE;
        end
      end
      crl_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          key_nxt   = {in_data.addr_high, in_data.addr_low};
          addr_nxt  = {in_data.addr_high, in_data.addr_low};
          now_nxt   = in_data.now_seconds;
          limit_nxt = in_data.conn_limit;
          h_nxt     = crl_pkg::HASH_SEED;
          step_nxt  = '0;
          if (in_data.conn_limit == 20'd0) begin
            // Unlimited client: straight to the result, nothing changes.
            state_nxt = crl_pkg::ST_DONE;
          end else begin
            state_nxt = crl_pkg::ST_HASH;
          end
        end
      end
      // One address byte per cycle: h = h*33 xor byte.
      crl_pkg::ST_HASH: begin
        h_nxt    = ((h_r << 5) + h_r) ^ {24'd0, key_r[127:120]};
        key_nxt  = key_r << 8;
        step_nxt = step_r + CNT_W'(1);
        if (step_r == CNT_W'(HASH_BYTES - 1)) begin
          step_nxt  = '0;
          state_nxt = crl_pkg::ST_DIVT;
        end
      end
      // Tick = now / TICK_SECONDS.
      crl_pkg::ST_DIVT: begin
        tick_nxt  = mul_q[TICK_W-1:0];
        state_nxt = crl_pkg::ST_DIVM;
      end
      // Quotient of tick / WINDOW_SLOTS; the remainder follows in the base step.
      crl_pkg::ST_DIVM: begin
        quo_nxt   = mul_q;
        prb_nxt   = h_r[IDX_W-1:0];
        state_nxt = crl_pkg::ST_PRB_RD;
      end
      // Probe read issued at prb_r.
      crl_pkg::ST_PRB_RD: begin
        state_nxt = crl_pkg::ST_PRB_CK;
      end
      // Track the least recently touched slot and look for the address.
      crl_pkg::ST_PRB_CK: begin
        if (step_r == '0 || t_q < oldest_lt_r) begin
          oldest_nxt    = prb_r;
          oldest_lt_nxt = t_q;
        end
        if (a_q == addr_r) begin
          slot_nxt  = prb_r;
          found_nxt = 1'b1;
          state_nxt = crl_pkg::ST_BASE;
        end else if (step_r == CNT_W'(PROBE_LIMIT - 1)) begin
          slot_nxt  = oldest_nxt;
          found_nxt = 1'b0;
          state_nxt = crl_pkg::ST_BASE;
        end else begin
          step_nxt  = step_r + CNT_W'(1);
          prb_nxt   = prb_r + IDX_W'(1);
          state_nxt = crl_pkg::ST_PRB_RD;
        end
      end
      // Bucket base address and bucket offset; a miss takes over the slot.
      crl_pkg::ST_BASE: begin
        base_nxt = BA_W'(slot_r) * BA_W'(WINDOW_SLOTS);
        off_nxt  = WI_W'(32'(tick_r) - quo_r * 32'(WINDOW_SLOTS));
        step_nxt = '0;
        if (found_r) begin
          state_nxt = crl_pkg::ST_UPD_RD;
        end else begin
          a_we      = 1'b1;
          state_nxt = crl_pkg::ST_WIPE;
        end
      end
      crl_pkg::ST_WIPE: begin
        b_we     = 1'b1;
        step_nxt = step_r + CNT_W'(1);
        if (step_r == CNT_W'(WINDOW_SLOTS - 1)) begin
          step_nxt  = '0;
          state_nxt = crl_pkg::ST_UPD_RD;
        end
      end
      crl_pkg::ST_UPD_RD: begin
        state_nxt = crl_pkg::ST_UPD_WR;
      end
      // Count this connection in the current tick's bucket.
      crl_pkg::ST_UPD_WR: begin
        b_we      = 1'b1;
        b_waddr   = base_r + BA_W'(off_r);
        b_wdata   = {tick_r, b_newcnt};
        step_nxt  = '0;
        sum_nxt   = '0;
        state_nxt = crl_pkg::ST_SUM_RD;
      end
      crl_pkg::ST_SUM_RD: begin
        b_raddr   = base_r + BA_W'(step_r);
        state_nxt = crl_pkg::ST_SUM_CK;
      end
      // Add buckets inside the window, saturating.
      crl_pkg::ST_SUM_CK: begin
        if (b_tick <= tick_r && b_diff <= TICK_W'(WINDOW_SLOTS)) begin
          sum_nxt = sum_wide[SW] ? crl_pkg::SUM_MAX : sum_wide[SW-1:0];
        end
        step_nxt = step_r + CNT_W'(1);
        if (step_r == CNT_W'(WINDOW_SLOTS - 1)) begin
          state_nxt = crl_pkg::ST_DONE;
        end else begin
          state_nxt = crl_pkg::ST_SUM_RD;
        end
      end
      // Post the result once the output is free; a limited client also touches its slot.
      crl_pkg::ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          if (limit_r == 20'd0) begin
            out_nxt = '0;
          end else begin
            t_we = 1'b1;
            out_nxt.connection_count = sum_r;
            out_nxt.slot_index       = OW'(slot_r);
            if (32'(limit_r) < 32'(sum_r)) begin
              out_nxt.action = drop_r ? crl_pkg::ACT_DROP : crl_pkg::ACT_TEMPFAIL;
            end else begin
              out_nxt.action = crl_pkg::ACT_CONTINUE;
            end
          end
          out_valid_nxt = 1'b1;
          state_nxt     = crl_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = crl_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

### verif/tb_top.sv
// Self-checking testbench for the client connection rate limiter.
// Depends on crl_pkg and client_connection_rate_limiter_unit only.
`timescale 1ns / 1ps

module tb_top;

  localparam int ENTRIES = crl_pkg::TABLE_ENTRIES_DEF;
  localparam int PROBES  = crl_pkg::PROBE_LIMIT_DEF;
  localparam int BUCKETS = crl_pkg::WINDOW_SLOTS_DEF;
  localparam int TICK_S  = crl_pkg::TICK_SECONDS_DEF;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  crl_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  crl_pkg::out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_data = 1'b0;

  client_connection_rate_limiter_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // Clock with a 10 ns period.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the client table and the window buckets.
  logic [63:0] shadow_high [ENTRIES];
  logic [63:0] shadow_low [ENTRIES];
  logic [31:0] shadow_touched [ENTRIES];
  logic [31:0] bucket_tick [ENTRIES*BUCKETS];
  logic [15:0] bucket_count [ENTRIES*BUCKETS];
  logic shadow_drop_mode = 1'b0;

  crl_pkg::in_item_t pending_conns [$];
  crl_pkg::out_item_t expected_verdicts [$];
  int errors = 0;
  bit quiet = 1'b0;
  bit in_taken = 1'b0;
  int send_gap = 0;
  int stall_left = 0;

  // Simulated wall clock and client address pools for the stimulus.
  logic [31:0] wall_now = 32'd0;
  logic [63:0] pool_high [3];
  logic [55:0] pool_low [3];

  task automatic report(string field, logic [31:0] got, logic [31:0] want);
    $display("%0t mismatch on %s: got %0d expected %0d", $time, field, got, want);
    errors++;
  endtask

  // Computes the verdict for one connection and updates the shadow state.
  function automatic crl_pkg::out_item_t rate_verdict(crl_pkg::in_item_t c);
    crl_pkg::out_item_t r;
    logic [31:0] h, s, oldest, hit, tick, base, b, sum;
    logic [127:0] addr;
    bit found;
    r = '0;
    if (c.conn_limit == 20'd0) return r;
    addr = {c.addr_high, c.addr_low};
    h = crl_pkg::HASH_SEED;
    for (int k = 15; k >= 0; k--) h = (h * 32'd33) ^ {24'd0, addr[k*8 +: 8]};
    h = h & (ENTRIES - 1);
    oldest = h;
    hit = h;
    found = 1'b0;
    for (int i = 0; i < PROBES; i++) begin
      s = (h + i) & (ENTRIES - 1);
      if (shadow_touched[s] < shadow_touched[oldest]) oldest = s;
      if (shadow_high[s] == c.addr_high && shadow_low[s] == c.addr_low) begin
        hit = s;
        found = 1'b1;
        break;
      end
    end
    // A miss takes over the least recently touched probed slot.
    if (!found) begin
      hit = oldest;
      for (int i = 0; i < BUCKETS; i++) begin
        bucket_tick[hit*BUCKETS + i] = '0;
        bucket_count[hit*BUCKETS + i] = '0;
      end
      shadow_high[hit] = c.addr_high;
      shadow_low[hit] = c.addr_low;
    end
    tick = c.now_seconds / TICK_S;
    base = hit * BUCKETS;
    b = base + tick % BUCKETS;
    if (bucket_tick[b] != tick) begin
      bucket_tick[b] = tick;
      bucket_count[b] = '0;
    end
    if (bucket_count[b] != crl_pkg::COUNT_MAX) bucket_count[b] = bucket_count[b] + 16'd1;
    // Sum the buckets that fall inside the window, saturating.
    sum = 0;
    for (int i = 0; i < BUCKETS; i++) begin
      if (bucket_tick[base+i] <= tick && tick - bucket_tick[base+i] <= BUCKETS) begin
        sum = sum + bucket_count[base+i];
        if (sum > crl_pkg::SUM_MAX) sum = crl_pkg::SUM_MAX;
      end
    end
    shadow_touched[hit] = c.now_seconds;
    if ({12'd0, c.conn_limit} < sum)
      r.action = shadow_drop_mode ? crl_pkg::ACT_DROP : crl_pkg::ACT_TEMPFAIL;
    else r.action = crl_pkg::ACT_CONTINUE;
    r.connection_count = sum[crl_pkg::SUM_W-1:0];
    r.slot_index = hit[crl_pkg::SLOT_W-1:0];
    return r;
  endfunction

  // Checks results and predicts accepted transactions at the rising edge.
  always @(posedge clk) begin
    crl_pkg::out_item_t want;
    if (out_valid && out_ready) begin
      if (expected_verdicts.size() == 0) begin
        $display("%0t result transaction with no expectation pending", $time);
        errors++;
      end else begin
        want = expected_verdicts.pop_front();
        if (out_data.action !== want.action) report("action", out_data.action, want.action);
        if (out_data.connection_count !== want.connection_count)
          report("connection_count", out_data.connection_count, want.connection_count);
        if (out_data.slot_index !== want.slot_index)
          report("slot_index", out_data.slot_index, want.slot_index);
      end
    end
    in_taken = in_valid && in_ready;
    if (in_taken) expected_verdicts.push_back(rate_verdict(in_data));
  end

  // Input driver with random bursts of idle cycles.
  always @(negedge clk) begin
    if (!in_valid || in_taken) begin
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        send_gap = $urandom_range(1, 9) - 1;
        in_valid <= 1'b0;
      end else if (pending_conns.size() > 0) begin
        in_data <= pending_conns.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result receiver with random stall bursts.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 9) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  function automatic crl_pkg::in_item_t conn(logic [63:0] hi, logic [63:0] lo,
                                             logic [31:0] now, logic [19:0] lim);
    crl_pkg::in_item_t c;
    c.addr_high = hi;
    c.addr_low = lo;
    c.now_seconds = now;
    c.conn_limit = lim;
    return c;
  endfunction

  // Random connection: mostly clients from three clustered address pools.
  function automatic crl_pkg::in_item_t random_conn();
    int pick, k;
    logic [63:0] hi, lo;
    logic [19:0] lim;
    pick = $urandom_range(0, 99);
    k = $urandom_range(0, 2);
    if (pick < 70) begin
      hi = pool_high[k];
      lo = {pool_low[k], 8'($urandom_range(0, 47))};
    end else if (pick < 85) begin
      hi = {$urandom, $urandom};
      lo = {$urandom, $urandom};
    end else begin
      hi = '0;
      lo = '0;
    end
    pick = $urandom_range(0, 99);
    if (pick < 3) wall_now = $urandom;
    else if (pick < 10) wall_now = wall_now + $urandom_range(0, 200);
    else wall_now = wall_now + $urandom_range(0, 3);
    pick = $urandom_range(0, 99);
    if (pick < 70) lim = 20'($urandom_range(1, 12));
    else if (pick < 80) lim = '0;
    else if (pick < 90) lim = 20'($urandom_range(1, 20'hFFFFF));
    else lim = '1;
    return conn(hi, lo, wall_now, lim);
  endfunction

  task automatic drain();
    while (pending_conns.size() > 0 || expected_verdicts.size() > 0 || in_valid)
      @(posedge clk);
    repeat (5) @(posedge clk);
  endtask

  task automatic write_drop_mode(logic mode);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= mode;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    shadow_drop_mode = mode;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic queue_random(int n);
    for (int i = 0; i < n; i++) pending_conns.push_back(random_conn());
  endtask

  // Sequence of phases across drop_mode settings.
  initial begin
    logic [63:0] ones;
    ones = '1;
    for (int i = 0; i < ENTRIES; i++) begin
      shadow_high[i] = '0;
      shadow_low[i] = '0;
      shadow_touched[i] = '0;
    end
    for (int i = 0; i < ENTRIES*BUCKETS; i++) begin
      bucket_tick[i] = '0;
      bucket_count[i] = '0;
    end
    for (int i = 0; i < 3; i++) begin
      pool_high[i] = {$urandom, $urandom};
      pool_low[i] = 56'({$urandom, $urandom});
    end
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    write_drop_mode(1'b0);

    // Directed: empty slot matching the zero address, unlimited, extremes.
    pending_conns.push_back(conn('0, '0, 32'd0, 20'd1));
    pending_conns.push_back(conn('0, '0, 32'd1, 20'd1));
    pending_conns.push_back(conn(ones, ones, 32'd2, 20'd0));
    pending_conns.push_back(conn(ones, ones, '1, '1));
    pending_conns.push_back(conn(ones, ones, '1, 20'd1));
    pending_conns.push_back(conn(64'h0123456789ABCDEF, 64'hFEDCBA9876543210, 32'd100, 20'd3));
    for (int i = 0; i < 4; i++)
      pending_conns.push_back(conn(64'h0123456789ABCDEF, 64'hFEDCBA9876543210,
                                   32'd101 + i, 20'd3));
    // Window boundary: a tick ten later reuses the old bucket; one eleven ticks old no longer counts.
    pending_conns.push_back(conn(64'h0123456789ABCDEF, 64'hFEDCBA9876543210, 32'd162, 20'd3));
    pending_conns.push_back(conn(64'h0123456789ABCDEF, 64'hFEDCBA9876543210, 32'd168, 20'd3));
    // Clustered addresses that differ only in the last byte and hash to neighbouring slots.
    for (int i = 0; i < 8; i++)
      pending_conns.push_back(conn(pool_high[0], {pool_low[0], 8'(i)}, 32'd200 + i, 20'd2));
    drain();

    write_drop_mode(1'b1);
    for (int i = 0; i < 4; i++)
      pending_conns.push_back(conn(64'hA5A5A5A5A5A5A5A5, 64'h5A5A5A5A5A5A5A5A, 32'd300, 20'd1));
    wall_now = 32'd400;
    queue_random(270);
    drain();

    write_drop_mode(1'b0);
    queue_random(280);
    drain();

    write_drop_mode(1'b1);
    quiet = 1'b1;
    queue_random(270);
    drain();
    repeat (200) @(posedge clk);
    if (errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  // Watchdog for a hung run.
  initial begin
    #10_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
